// ===== hdl/stcc_pkg.sv =====
// shared types and constants for the segment/triangle crossing classifier
// no dependencies; imported by every module of the block

package stcc_pkg;

    // default coordinate width and packed vertex register width
    localparam int COORD_BITS_DEF = 16;
    localparam int VERTEX_W       = 48;

    // configuration port geometry (64-bit data, registers at 8*i)
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 5;
    localparam int REG_IDX_LSB = 3;

    // register indexes
    localparam logic [1:0] REG_VERTEX_A = 2'd0;
    localparam logic [1:0] REG_VERTEX_B = 2'd1;
    localparam logic [1:0] REG_VERTEX_C = 2'd2;

    // pipeline depth: six volume stages plus the output register
    localparam int VOL_STAGES = 6;
    localparam int PIPE_DEPTH = VOL_STAGES + 1;

    // result codes
    typedef enum logic [2:0] {
        HIT_NONE   = 3'd0,
        HIT_VERTEX = 3'd1,
        HIT_EDGE   = 3'd2,
        HIT_FACE   = 3'd3,
        HIT_DEGEN  = 3'd4
    } hit_kind_t;

    // per-stage load enables of the volume pipeline, diff is the first stage
    typedef struct packed {
        logic sign;
        logic sum;
        logic part;
        logic minor;
        logic prod;
        logic diff;
    } vol_adv_t;

    // sign of one tetrahedron volume
    typedef struct packed {
        logic pos;
        logic neg;
    } vol_sign_t;

endpackage

// ===== hdl/segment_triangle_cross_classify.sv =====
// segment/triangle crossing classifier by signed tetrahedron volumes
// each input beat passes the volume stages diff, prod, minor, part, sum, sign and then the output register
// throughput: one beat per cycle unless back-pressure fills the pipeline; each pipeline stage holds on its own, so
// bubbles close up under back-pressure and s_ready is low only when all 7 are full
// reset: synchronous active-low aresetn clears the stage valids and the vertex registers
// depends on stcc_pkg, stcc_cfg, stcc_vol

module segment_triangle_cross_classify
    import stcc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         aclk,
    input  logic                         aresetn,
    // configuration port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [CFG_ADDR_W-1:0]        paddr,
    input  logic [CFG_DATA_W-1:0]        pwdata,
    output logic [CFG_DATA_W-1:0]        prdata,
    output logic                         pready,
    // segment input channel
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic signed [COORD_BITS-1:0] s_start_x,
    input  logic signed [COORD_BITS-1:0] s_start_y,
    input  logic signed [COORD_BITS-1:0] s_start_z,
    input  logic signed [COORD_BITS-1:0] s_end_x,
    input  logic signed [COORD_BITS-1:0] s_end_y,
    input  logic signed [COORD_BITS-1:0] s_end_z,
    // result channel
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_hit_kind
);

    localparam int VW = 3 * COORD_BITS;

    logic [VERTEX_W-1:0]          vertex_a, vertex_b, vertex_c;
    logic [VW-1:0]                vtx_a_pad, vtx_b_pad, vtx_c_pad;
    logic signed [COORD_BITS-1:0] pt_q [3];
    logic signed [COORD_BITS-1:0] pt_r [3];
    logic signed [COORD_BITS-1:0] pt_a [3];
    logic signed [COORD_BITS-1:0] pt_b [3];
    logic signed [COORD_BITS-1:0] pt_c [3];

    logic [PIPE_DEPTH-1:0] valid_reg, valid_next;
    logic [PIPE_DEPTH:0]   stage_rdy;
    logic [PIPE_DEPTH-1:0] stage_in_vld;
    logic [PIPE_DEPTH-1:0] stage_load;
    vol_adv_t              adv;
    vol_sign_t             vs0, vs1, vs2;
    logic [2:0]            pos_vec, neg_vec, zero_vec;
    hit_kind_t             kind_reg, kind_next;

    // configuration registers
    stcc_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .vertex_a (vertex_a),
        .vertex_b (vertex_b),
        .vertex_c (vertex_c)
    );

    assign pready = 1'b1;

    // unpack vertices; bits beyond the packed register read as zero
    assign vtx_a_pad = VW'(vertex_a);
    assign vtx_b_pad = VW'(vertex_b);
    assign vtx_c_pad = VW'(vertex_c);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            pt_a[k] = $signed(vtx_a_pad[k*COORD_BITS +: COORD_BITS]);
            pt_b[k] = $signed(vtx_b_pad[k*COORD_BITS +: COORD_BITS]);
            pt_c[k] = $signed(vtx_c_pad[k*COORD_BITS +: COORD_BITS]);
        end
    end

    assign pt_q[0] = s_start_x;
    assign pt_q[1] = s_start_y;
    assign pt_q[2] = s_start_z;
    assign pt_r[0] = s_end_x;
    assign pt_r[1] = s_end_y;
    assign pt_r[2] = s_end_z;

    // per-stage ready chain: a stage loads when empty or when it drains
    always_comb begin
        stage_rdy[PIPE_DEPTH] = m_ready;
        for (int i = PIPE_DEPTH - 1; i >= 0; i--) begin
            stage_rdy[i] = !valid_reg[i] || stage_rdy[i+1];
        end
    end

    assign stage_in_vld = {valid_reg[PIPE_DEPTH-2:0], s_valid};
    assign stage_load   = stage_rdy[PIPE_DEPTH-1:0] & stage_in_vld;
    assign adv          = vol_adv_t'(stage_load[VOL_STAGES-1:0]);

    always_comb begin
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            valid_next[i] = stage_rdy[i] ? stage_in_vld[i] : valid_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // the three volumes (q,a,b,r), (q,b,c,r), (q,c,a,r)
    stcc_vol #(.COORD_BITS(COORD_BITS)) u_vol_ab (
        .aclk (aclk), .adv (adv), .q (pt_q), .r (pt_r), .p1 (pt_a), .p2 (pt_b), .sign (vs0)
    );

    stcc_vol #(.COORD_BITS(COORD_BITS)) u_vol_bc (
        .aclk (aclk), .adv (adv), .q (pt_q), .r (pt_r), .p1 (pt_b), .p2 (pt_c), .sign (vs1)
    );

    stcc_vol #(.COORD_BITS(COORD_BITS)) u_vol_ca (
        .aclk (aclk), .adv (adv), .q (pt_q), .r (pt_r), .p1 (pt_c), .p2 (pt_a), .sign (vs2)
    );

    // classify the sign pattern
    assign pos_vec  = {vs2.pos, vs1.pos, vs0.pos};
    assign neg_vec  = {vs2.neg, vs1.neg, vs0.neg};
    assign zero_vec = ~(pos_vec | neg_vec);

    always_comb begin
        if ((&pos_vec) || (&neg_vec)) begin
            kind_next = HIT_FACE;
        end else if ((|pos_vec) && (|neg_vec)) begin
            kind_next = HIT_NONE;
        end else begin
            case (zero_vec) inside
                3'b111:                 kind_next = HIT_DEGEN;
                3'b011, 3'b101, 3'b110: kind_next = HIT_VERTEX;
                default:                kind_next = HIT_EDGE;
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (stage_load[PIPE_DEPTH-1]) begin
            kind_reg <= kind_next;
        end
    end

    assign s_ready    = stage_rdy[0];
    assign m_valid    = valid_reg[PIPE_DEPTH-1];
    assign m_hit_kind = kind_reg;

endmodule

// ===== hdl/stcc_cfg.sv =====
// configuration register file: triangle vertices a, b, c behind an apb-style port
// depends on stcc_pkg

module stcc_cfg
    import stcc_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic [VERTEX_W-1:0]   vertex_a,
    output logic [VERTEX_W-1:0]   vertex_b,
    output logic [VERTEX_W-1:0]   vertex_c
);

    logic [VERTEX_W-1:0] vtx_a_reg, vtx_a_next;
    logic [VERTEX_W-1:0] vtx_b_reg, vtx_b_next;
    logic [VERTEX_W-1:0] vtx_c_reg, vtx_c_next;
    logic [1:0]          reg_idx;
    logic                wr_en;

    assign reg_idx = paddr[CFG_ADDR_W-1:REG_IDX_LSB];
    assign wr_en   = psel && penable && pwrite;

    // write decode
    always_comb begin
        vtx_a_next = vtx_a_reg;
        vtx_b_next = vtx_b_reg;
        vtx_c_next = vtx_c_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_VERTEX_A: vtx_a_next = pwdata[VERTEX_W-1:0];
                REG_VERTEX_B: vtx_b_next = pwdata[VERTEX_W-1:0];
                REG_VERTEX_C: vtx_c_next = pwdata[VERTEX_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vtx_a_reg <= '0;
            vtx_b_reg <= '0;
            vtx_c_reg <= '0;
        end else begin
            vtx_a_reg <= vtx_a_next;
            vtx_b_reg <= vtx_b_next;
            vtx_c_reg <= vtx_c_next;
        end
    end

    // read mux
    always_comb begin
        unique case (reg_idx)
            REG_VERTEX_A: prdata = CFG_DATA_W'(vtx_a_reg);
            REG_VERTEX_B: prdata = CFG_DATA_W'(vtx_b_reg);
            REG_VERTEX_C: prdata = CFG_DATA_W'(vtx_c_reg);
            default:      prdata = '0;
        endcase
    end

    assign vertex_a = vtx_a_reg;
    assign vertex_b = vtx_b_reg;
    assign vertex_c = vtx_c_reg;

endmodule

// ===== hdl/stcc_vol.sv =====
// six-stage pipeline giving the exact sign of det[q-r, p1-r, p2-r]
// depends on stcc_pkg; load enables come from the top level valid chain

module stcc_vol
    import stcc_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
)
(
    input  logic                         aclk,
    input  vol_adv_t                     adv,
    input  logic signed [COORD_BITS-1:0] q  [3],
    input  logic signed [COORD_BITS-1:0] r  [3],
    input  logic signed [COORD_BITS-1:0] p1 [3],
    input  logic signed [COORD_BITS-1:0] p2 [3],
    output vol_sign_t                    sign
);

    // widths: differences, products, minors, split minor, partial sums, total
    localparam int DW  = COORD_BITS + 1;
    localparam int PW  = 2 * DW;
    localparam int MW  = PW + 1;
    localparam int LW  = DW;
    localparam int HW  = MW - LW;
    localparam int HPW = HW + DW;
    localparam int LPW = LW + 1 + DW;
    localparam int HS  = HPW + 2;
    localparam int LS  = LPW + 2;
    localparam int TW  = HS + LW + 1;

    logic signed [DW-1:0]  d1_reg [3], d1_next [3];
    logic signed [DW-1:0]  e1_reg [3], e1_next [3];
    logic signed [DW-1:0]  f1_reg [3], f1_next [3];
    logic signed [DW-1:0]  d2_reg [3];
    logic signed [PW-1:0]  pa_reg [3], pa_next [3];
    logic signed [PW-1:0]  pb_reg [3], pb_next [3];
    logic signed [DW-1:0]  d3_reg [3];
    logic signed [MW-1:0]  m_reg  [3], m_next  [3];
    logic signed [HPW-1:0] ph_reg [3], ph_next [3];
    logic signed [LPW-1:0] pl_reg [3], pl_next [3];
    logic signed [HS-1:0]  hs_reg, hs_next;
    logic signed [LS-1:0]  ls_reg, ls_next;
    logic signed [TW-1:0]  total;
    vol_sign_t             sign_reg, sign_next;

    // stage 1: edge vectors relative to r
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            d1_next[i] = DW'(q[i])  - DW'(r[i]);
            e1_next[i] = DW'(p1[i]) - DW'(r[i]);
            f1_next[i] = DW'(p2[i]) - DW'(r[i]);
        end
    end

    // stage 2: the six cross-product terms
    always_comb begin
        pa_next[0] = PW'(e1_reg[1]) * PW'(f1_reg[2]);
        pb_next[0] = PW'(e1_reg[2]) * PW'(f1_reg[1]);
        pa_next[1] = PW'(e1_reg[2]) * PW'(f1_reg[0]);
        pb_next[1] = PW'(e1_reg[0]) * PW'(f1_reg[2]);
        pa_next[2] = PW'(e1_reg[0]) * PW'(f1_reg[1]);
        pb_next[2] = PW'(e1_reg[1]) * PW'(f1_reg[0]);
    end

    // stage 3: cross-product components
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_next[i] = MW'(pa_reg[i]) - MW'(pb_reg[i]);
        end
    end

    // stage 4: minor split into signed high and unsigned low halves, times d
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ph_next[i] = HPW'($signed(m_reg[i][MW-1:LW])) * HPW'(d3_reg[i]);
            pl_next[i] = LPW'($signed({1'b0, m_reg[i][LW-1:0]})) * LPW'(d3_reg[i]);
        end
    end

    // stage 5: sum the partial products of each half
    assign hs_next = HS'(ph_reg[0]) + HS'(ph_reg[1]) + HS'(ph_reg[2]);
    assign ls_next = LS'(pl_reg[0]) + LS'(pl_reg[1]) + LS'(pl_reg[2]);

    // stage 6: recombine halves and take the sign
    assign total          = (TW'(hs_reg) <<< LW) + TW'(ls_reg);
    assign sign_next.neg  = total[TW-1];
    assign sign_next.pos  = !total[TW-1] && (total != '0);

    always_ff @(posedge aclk) begin
        if (adv.diff) begin
            d1_reg <= d1_next;
            e1_reg <= e1_next;
            f1_reg <= f1_next;
        end
        if (adv.prod) begin
            d2_reg <= d1_reg;
            pa_reg <= pa_next;
            pb_reg <= pb_next;
        end
        if (adv.minor) begin
            d3_reg <= d2_reg;
            m_reg  <= m_next;
        end
        if (adv.part) begin
            ph_reg <= ph_next;
            pl_reg <= pl_next;
        end
        if (adv.sum) begin
            hs_reg <= hs_next;
            ls_reg <= ls_next;
        end
        if (adv.sign) begin
            sign_reg <= sign_next;
        end
    end

    assign sign = sign_reg;

endmodule

// ===== hdl/stcc_checker.sv =====
// port-level checks for segment_triangle_cross_classify, attached by bind
// depends on stcc_pkg

module stcc_checker
    import stcc_pkg::*;
(
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [2:0] m_hit_kind
);

    // a held result beat keeps its value
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit_kind))
        else $error("result beat changed while stalled");

    // reset empties the pipeline
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // the pipeline only pushes back when every stage is full and the sink stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready)
        else $error("input stalled without output back-pressure");

    // an empty sink never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input not ready while output drains");

    // an input beat accepted while the sink stalls, after a sample with s_ready low, needs m_valid high in that sample
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_ready && $past(!s_ready) |-> $past(m_valid))
        else $error("input accepted into a full pipeline");

endmodule

bind segment_triangle_cross_classify stcc_checker u_stcc_checker (
    .aclk       (aclk),
    .aresetn    (aresetn),
    .s_valid    (s_valid),
    .s_ready    (s_ready),
    .m_valid    (m_valid),
    .m_ready    (m_ready),
    .m_hit_kind (m_hit_kind)
);

// ===== dv/testbench.sv =====
// self-checking testbench for segment_triangle_cross_classify
// drives segment beats and APB vertex writes, predicts hit_kind with exact volume signs
// depends on stcc_pkg and the segment_triangle_cross_classify RTL

module testbench
    import stcc_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // one segment beat as driven on the input channel
    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] sy;
        logic signed [15:0] sz;
        logic signed [15:0] ex;
        logic signed [15:0] ey;
        logic signed [15:0] ez;
    } seg_beat_t;

    // index that decodes to no register
    localparam logic [1:0] REG_UNUSED = 2'd3;

    // predicts the crossing class and holds the expected results in order
    class hit_scoreboard;
        logic [VERTEX_W-1:0] vtx [3];
        hit_kind_t           pending [$];
        int                  errors;
        int                  kind_count [5];

        function new();
            for (int k = 0; k < 3; k++) vtx[k] = '0;
            errors = 0;
            for (int k = 0; k < 5; k++) kind_count[k] = 0;
        endfunction

        function void write_register(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
            logic [1:0] idx;
            idx = 2'(addr >> REG_IDX_LSB);
            case (idx)
                REG_VERTEX_A: vtx[0] = data[VERTEX_W-1:0];
                REG_VERTEX_B: vtx[1] = data[VERTEX_W-1:0];
                REG_VERTEX_C: vtx[2] = data[VERTEX_W-1:0];
                default: ;
            endcase
        endfunction

        // exact sign of det[p-r, u-r, w-r]
        function int volume_sign(longint p[3], longint u[3], longint w[3], longint r[3]);
            longint d[3], e[3], f[3], det;
            for (int k = 0; k < 3; k++) begin
                d[k] = p[k] - r[k];
                e[k] = u[k] - r[k];
                f[k] = w[k] - r[k];
            end
            det = d[0] * (e[1] * f[2] - e[2] * f[1])
                + d[1] * (e[2] * f[0] - e[0] * f[2])
                + d[2] * (e[0] * f[1] - e[1] * f[0]);
            return (det > 0) ? 1 : ((det < 0) ? -1 : 0);
        endfunction

        function hit_kind_t classify(seg_beat_t s);
            longint    q[3], r[3], a[3], b[3], c[3];
            int        s0, s1, s2, zeros;
            bit        anypos, anyneg;
            hit_kind_t kind;
            for (int k = 0; k < 3; k++) begin
                a[k] = $signed(vtx[0][16*k +: 16]);
                b[k] = $signed(vtx[1][16*k +: 16]);
                c[k] = $signed(vtx[2][16*k +: 16]);
            end
            q[0] = $signed(s.sx); q[1] = $signed(s.sy); q[2] = $signed(s.sz);
            r[0] = $signed(s.ex); r[1] = $signed(s.ey); r[2] = $signed(s.ez);
            s0 = volume_sign(q, a, b, r);
            s1 = volume_sign(q, b, c, r);
            s2 = volume_sign(q, c, a, r);
            anypos = (s0 > 0) || (s1 > 0) || (s2 > 0);
            anyneg = (s0 < 0) || (s1 < 0) || (s2 < 0);
            zeros  = int'(s0 == 0) + int'(s1 == 0) + int'(s2 == 0);
            if ((s0 > 0 && s1 > 0 && s2 > 0) || (s0 < 0 && s1 < 0 && s2 < 0))
                kind = HIT_FACE;
            else if (anypos && anyneg)
                kind = HIT_NONE;
            else if (zeros == 3)
                kind = HIT_DEGEN;
            else if (zeros == 2)
                kind = HIT_VERTEX;
            else
                kind = HIT_EDGE;
            return kind;
        endfunction

        function void note_segment(seg_beat_t s);
            hit_kind_t kind;
            kind = classify(s);
            kind_count[kind]++;
            pending = {pending, kind};
        endfunction

        function void check_hit(logic [2:0] got);
            hit_kind_t want;
            if (pending.size() == 0) begin
                $display("%0t: result beat with nothing expected, actual %0d", $time, got);
                errors++;
            end else begin
                want = pending.pop_front();
                if (got !== want) begin
                    $display("%0t: hit_kind mismatch, expected %0d (%s) actual %0d",
                             $time, want, want.name(), got);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0]        paddr = '0;
    logic [CFG_DATA_W-1:0]        pwdata = '0;
    logic [CFG_DATA_W-1:0]        prdata;
    logic                         pready;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [15:0]           s_start_x = '0;
    logic signed [15:0]           s_start_y = '0;
    logic signed [15:0]           s_start_z = '0;
    logic signed [15:0]           s_end_x = '0;
    logic signed [15:0]           s_end_y = '0;
    logic signed [15:0]           s_end_z = '0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [2:0]                   m_hit_kind;

    hit_scoreboard sb = new();

    int send_idle = 20;
    int recv_idle = 52;
    int tri_pt [3][3];
    int settings_done = 0;

    segment_triangle_cross_classify u_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_start_x  (s_start_x),
        .s_start_y  (s_start_y),
        .s_start_z  (s_start_z),
        .s_end_x    (s_end_x),
        .s_end_y    (s_end_y),
        .s_end_z    (s_end_z),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_hit_kind (m_hit_kind)
    );

    // 10 ns clock
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver back-pressure
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle);
    end

    // result beat check
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_hit(m_hit_kind);
    end

    // hang guard
    initial begin
        #(5_000_000);
        $display("simulation failed");
        $finish;
    end

    function automatic int srand(int m);
        return int'($urandom_range(2 * m)) - m;
    endfunction

    function automatic logic [CFG_ADDR_W-1:0] reg_addr(logic [1:0] idx);
        return CFG_ADDR_W'(idx) << REG_IDX_LSB;
    endfunction

    task automatic wait_drain();
        while (sb.pending.size() != 0) @(negedge aclk);
    endtask

    // APB write with setup and access phases, only once the pipe is empty
    task automatic apb_write(logic [CFG_ADDR_W-1:0] addr, logic [CFG_DATA_W-1:0] data);
        s_valid = 1'b0;
        wait_drain();
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_register(addr, data);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // write all three vertices and keep the wrapped coordinates for stimulus
    task automatic write_vertex_set(logic [63:0] da, logic [63:0] db, logic [63:0] dc);
        apb_write(reg_addr(REG_VERTEX_A), da);
        apb_write(reg_addr(REG_VERTEX_B), db);
        apb_write(reg_addr(REG_VERTEX_C), dc);
        for (int k = 0; k < 3; k++) begin
            tri_pt[0][k] = $signed(da[16*k +: 16]);
            tri_pt[1][k] = $signed(db[16*k +: 16]);
            tri_pt[2][k] = $signed(dc[16*k +: 16]);
        end
        settings_done++;
    endtask

    // pack tri_pt with random junk above bit 47
    task automatic write_triangle();
        logic [63:0] d [3];
        for (int j = 0; j < 3; j++) begin
            d[j] = {$urandom, $urandom};
            d[j][47:0] = {16'(tri_pt[j][2]), 16'(tri_pt[j][1]), 16'(tri_pt[j][0])};
        end
        write_vertex_set(d[0], d[1], d[2]);
    endtask

    task automatic set_triangle(int ax, int ay, int az, int bx, int by, int bz,
                                int cx, int cy, int cz);
        tri_pt[0][0] = ax; tri_pt[0][1] = ay; tri_pt[0][2] = az;
        tri_pt[1][0] = bx; tri_pt[1][1] = by; tri_pt[1][2] = bz;
        tri_pt[2][0] = cx; tri_pt[2][1] = cy; tri_pt[2][2] = cz;
        write_triangle();
    endtask

    // one segment beat, entered at a falling edge, left at a falling edge
    task automatic send_segment(seg_beat_t s);
        while ($urandom_range(99) < send_idle) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_start_x = s.sx;
        s_start_y = s.sy;
        s_start_z = s.sz;
        s_end_x   = s.ex;
        s_end_y   = s.ey;
        s_end_z   = s.ez;
        do @(posedge aclk); while (!s_ready);
        sb.note_segment(s);
        @(negedge aclk);
    endtask

    task automatic send_xyz(int qx, int qy, int qz, int rx, int ry, int rz);
        seg_beat_t s;
        s.sx = 16'(qx); s.sy = 16'(qy); s.sz = 16'(qz);
        s.ex = 16'(rx); s.ey = 16'(ry); s.ez = 16'(rz);
        send_segment(s);
    endtask

    // triangles mostly as a, a+6u, a+6v so edge points and the centroid are integers
    task automatic pick_triangle();
        int sel, span, step;
        int a[3], u[3], v[3];
        sel = $urandom_range(5);
        if (sel == 5) begin
            write_vertex_set({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
        end else if (sel == 4) begin
            for (int j = 0; j < 3; j++)
                for (int k = 0; k < 3; k++)
                    tri_pt[j][k] = $urandom_range(1) ? 32767 : -32768;
            write_triangle();
        end else begin
            span = (sel == 2) ? 100 : 14000;
            step = (sel == 2) ? 10 : 1000;
            for (int k = 0; k < 3; k++) begin
                a[k] = srand(span);
                u[k] = srand(step);
                // collinear vertices give a degenerate triangle
                v[k] = (sel == 3) ? 2 * u[k] : srand(step);
                tri_pt[0][k] = a[k];
                tri_pt[1][k] = a[k] + 6 * u[k];
                tri_pt[2][k] = a[k] + 6 * v[k];
            end
            write_triangle();
        end
    endtask

    // mostly lines through a lattice point of the triangle, some pure noise
    function automatic seg_beat_t random_segment();
        seg_beat_t s;
        int p[3], t[3], q[3], r[3];
        int i, j, m1, m2, mult, form;
        if ($urandom_range(4) == 0) begin
            s = {$urandom, $urandom, $urandom};
            return s;
        end
        i    = $urandom_range(6);
        j    = $urandom_range(6 - i);
        m1   = srand(2);
        m2   = srand(2);
        form = $urandom_range(9);
        mult = (form == 9) ? -2 : int'($urandom_range(1, 2));
        for (int k = 0; k < 3; k++) begin
            p[k] = tri_pt[0][k] + (i * (tri_pt[1][k] - tri_pt[0][k])
                                 + j * (tri_pt[2][k] - tri_pt[0][k])) / 6;
            if (form < 2)
                // direction within the triangle plane
                t[k] = (m1 * (tri_pt[1][k] - tri_pt[0][k])
                      + m2 * (tri_pt[2][k] - tri_pt[0][k])) / 6;
            else if (form < 4)
                t[k] = srand(3);
            else
                t[k] = srand(3000);
            q[k] = p[k] + t[k];
            r[k] = p[k] - mult * t[k];
        end
        s.sx = 16'(q[0]); s.sy = 16'(q[1]); s.sz = 16'(q[2]);
        s.ex = 16'(r[0]); s.ey = 16'(r[1]); s.ez = 16'(r[2]);
        return s;
    endfunction

    initial begin
        // reset
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;

        // all vertices zero after reset: every segment is degenerate
        send_xyz(-32768, -32768, -32768, 32767, 32767, 32767);
        send_xyz(0, 0, 0, 0, 0, 0);

        // right triangle in the z=0 plane
        set_triangle(0, 0, 0, 600, 0, 0, 0, 600, 0);
        send_xyz(100, 100, -50, 100, 100, 50);
        send_xyz(100, 100, 50, 100, 100, -50);
        send_xyz(500, 500, -50, 500, 500, 50);
        send_xyz(300, 0, -50, 300, 0, 50);
        send_xyz(0, 0, -50, 0, 0, 50);
        send_xyz(600, 0, -7, 600, 0, 9);
        send_xyz(10, 10, 0, 20, 20, 0);

        // write to the unused index must leave the triangle alone
        apb_write(reg_addr(REG_UNUSED), '1);
        send_xyz(100, 100, -50, 100, 100, 50);

        // triangle on the corners of the coordinate range
        set_triangle(-32768, -32768, -32768, 32767, -32768, 32767, -32768, 32767, 32767);
        send_xyz(32767, 32767, -32768, -32768, -32768, 32767);
        send_xyz(32767, 32767, 32767, -32768, -32768, -32768);
        send_xyz(-32768, -32768, -32768, 32767, 32767, 32767);
        send_xyz(0, 0, 0, 32767, -32768, -32768);

        // all ones in every register: a point triangle at (-1,-1,-1)
        write_vertex_set('1, '1, '1);
        send_xyz(32767, 32767, 32767, -32768, -32768, -32768);
        send_xyz(1, 2, 3, -4, -5, -6);

        // random phases under three idling mixes
        for (int phase = 0; phase < 12; phase++) begin
            send_idle = (phase < 4) ? 20 : ((phase < 8) ? 52 : 0);
            recv_idle = (phase < 4) ? 52 : ((phase < 8) ? 20 : 0);
            pick_triangle();
            for (int n = 0; n < 78; n++) send_segment(random_segment());
        end

        // drain and look for stray beats
        s_valid = 1'b0;
        wait_drain();
        repeat (PIPE_DEPTH * 4) @(negedge aclk);

        $display("ran %0d triangle settings; expected none %0d, vertex %0d, edge %0d",
                 settings_done, sb.kind_count[HIT_NONE], sb.kind_count[HIT_VERTEX],
                 sb.kind_count[HIT_EDGE]);
        $display("face %0d, degenerate %0d, mismatches %0d",
                 sb.kind_count[HIT_FACE], sb.kind_count[HIT_DEGEN], sb.errors);
        if (sb.errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
